/* rtl/wpsp_pkg.sv */
// WAV PCM stream parser: shared types and constants.
// No dependencies; compiled first.
`default_nettype none

package wpsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] PCM_CODE = 16'd1;
    localparam logic [15:0] MAX_CHANNELS = 16'd2;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NOT_PCM   = 3'd0;
    localparam logic [2:0] ERR_CHANNELS  = 3'd1;
    localparam logic [2:0] ERR_NOT_RIFF  = 3'd2;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd3;
    localparam logic [2:0] ERR_NO_FMT    = 3'd4;
    localparam logic [2:0] ERR_BAD_WIDTH = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sample_word;
        logic        channel;
        logic [31:0] frame_index;
        logic        last;
        logic [1:0]  chan_count;
        logic [4:0]  sample_bits;
        logic [31:0] rate_hz;
        logic [31:0] bytes_per_sec;
        logic [31:0] frame_total;
        logic [31:0] audio_offset;
        logic [2:0]  error_code;
    } t_result;

endpackage

`default_nettype wire

/* rtl/wpsp_stream_if.sv */
// Valid/ready channel interfaces for the WAV parser: byte input and result output.
// No dependencies.
`default_nettype none

interface wpsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;

    modport source (output valid, output file_byte, output start_of_file, input ready);
    modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface wpsp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] sample_word;
    logic        channel;
    logic [31:0] frame_index;
    logic        last;
    logic [1:0]  chan_count;
    logic [4:0]  sample_bits;
    logic [31:0] rate_hz;
    logic [31:0] bytes_per_sec;
    logic [31:0] frame_total;
    logic [31:0] audio_offset;
    logic [2:0]  error_code;

    modport source (
        output valid, input ready,
        output kind, output sample_word, output channel, output frame_index, output last,
        output chan_count, output sample_bits, output rate_hz, output bytes_per_sec,
        output frame_total, output audio_offset, output error_code
    );
    modport sink (
        input valid, output ready,
        input kind, input sample_word, input channel, input frame_index, input last,
        input chan_count, input sample_bits, input rate_hz, input bytes_per_sec,
        input frame_total, input audio_offset, input error_code
    );
endinterface

`default_nettype wire

/* rtl/wav_pcm_stream_parser_top.sv */
// WAV PCM stream parser top level: byte channel in, result channel out.
// Depends on wpsp_pkg, wpsp_stream_if, wpsp_core, wpsp_out_reg.
//
//   channel   dir  payload                                        transfer
//   i_in      in   file_byte, start_of_file                       valid & ready
//   o_out     out  kind, sample, frame, format and error fields   valid & ready
//
// One byte per cycle; a result appears on o_out the cycle after its byte transfer.
// Only a sample's last byte or the last byte of a (chunk) header can give a result.
// i_in.ready drops only while a result is held and o_out.ready is low.
// Synchronous active-low reset returns to the header phase at byte 0.
`default_nettype none

module wav_pcm_stream_parser_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    wpsp_byte_if.sink     i_in,
    wpsp_result_if.source o_out
);

    logic              take;
    logic              res_valid;
    wpsp_pkg::t_result res;
    wpsp_pkg::t_result out_res;
    logic              in_ready;

    assign i_in.ready = in_ready;
    assign take       = i_in.valid && in_ready;

    wpsp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_file_byte     (i_in.file_byte),
        .i_start_of_file (i_in.start_of_file),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    wpsp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .o_out       (out_res)
    );

    assign o_out.kind          = out_res.kind;
    assign o_out.sample_word   = out_res.sample_word;
    assign o_out.channel       = out_res.channel;
    assign o_out.frame_index   = out_res.frame_index;
    assign o_out.last          = out_res.last;
    assign o_out.chan_count    = out_res.chan_count;
    assign o_out.sample_bits   = out_res.sample_bits;
    assign o_out.rate_hz       = out_res.rate_hz;
    assign o_out.bytes_per_sec = out_res.bytes_per_sec;
    assign o_out.frame_total   = out_res.frame_total;
    assign o_out.audio_offset  = out_res.audio_offset;
    assign o_out.error_code    = out_res.error_code;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty result register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_last_is_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.kind == wpsp_pkg::KIND_SAMPLE))
        else $error("last flag on a non-sample result");

    a_error_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == wpsp_pkg::KIND_ERROR)
            |-> (o_out.error_code <= wpsp_pkg::ERR_BAD_WIDTH))
        else $error("error code out of range");

endmodule

`default_nettype wire

/* rtl/wpsp_core.sv */
// WAV parser state: header capture and checks, chunk walk, sample unpacking.
// Depends on wpsp_pkg. One byte per accepted transfer, result decided combinationally.
`default_nettype none

module wpsp_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [7:0]       i_file_byte,
    input  wire logic             i_start_of_file,
    output logic                  o_res_valid,
    output wpsp_pkg::t_result     o_res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHUNK  = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    localparam logic [31:0] POS_RIFF  = 32'd3;
    localparam logic [31:0] POS_WAVE  = 32'd11;
    localparam logic [31:0] POS_FMT   = 32'd15;
    localparam logic [31:0] POS_PCM   = 32'd21;
    localparam logic [31:0] POS_CHAN  = 32'd23;
    localparam logic [31:0] POS_RATE  = 32'd27;
    localparam logic [31:0] POS_BRATE = 32'd31;
    localparam logic [31:0] POS_WIDTH = 32'd35;

    localparam logic [2:0] FS_TAG_END  = 3'd3;
    localparam logic [2:0] FS_HDR_LAST = 3'd7;

    logic [2:0]  r_phase, n_phase, s_phase;
    logic [31:0] r_pos, n_pos, s_pos;
    logic [2:0]  r_fs, n_fs, s_fs;
    logic        r_stereo, n_stereo, s_stereo;
    logic        r_chan_ok, n_chan_ok, s_chan_ok;
    logic [31:0] r_rate, n_rate, s_rate;
    logic [31:0] r_brate, n_brate, s_brate;
    logic        r_wide, n_wide, s_wide;
    logic        r_ck_riff, n_ck_riff, s_ck_riff;
    logic        r_ck_wave, n_ck_wave, s_ck_wave;
    logic        r_ck_fmt, n_ck_fmt, s_ck_fmt;
    logic        r_ck_pcm, n_ck_pcm, s_ck_pcm;
    logic        r_ck_data, n_ck_data, s_ck_data;
    logic [31:0] r_tag, n_tag, s_tag;
    logic [31:0] r_remain, n_remain, s_remain;
    logic [31:0] r_left, n_left, s_left;
    logic [31:0] r_count, n_count, s_count;
    logic [7:0]  r_hold, n_hold, s_hold;
    logic        r_toggle, n_toggle, s_toggle;

    logic [15:0] half;
    logic [31:0] total;
    logic        frame_end;
    logic        width_ok;

    always_comb begin
        // start_of_file restarts from the reset state before this byte is used
        if (i_start_of_file) begin
            s_phase = PH_HEADER; s_pos = '0; s_fs = '0; s_stereo = 1'b0; s_chan_ok = 1'b0;
            s_rate = '0; s_brate = '0; s_wide = 1'b0; s_ck_riff = 1'b0; s_ck_wave = 1'b0;
            s_ck_fmt = 1'b0; s_ck_pcm = 1'b0; s_ck_data = 1'b0; s_tag = '0; s_remain = '0;
            s_left = '0; s_count = '0; s_hold = '0; s_toggle = 1'b0;
        end else begin
            s_phase = r_phase; s_pos = r_pos; s_fs = r_fs; s_stereo = r_stereo;
            s_chan_ok = r_chan_ok; s_rate = r_rate; s_brate = r_brate; s_wide = r_wide;
            s_ck_riff = r_ck_riff; s_ck_wave = r_ck_wave; s_ck_fmt = r_ck_fmt;
            s_ck_pcm = r_ck_pcm; s_ck_data = r_ck_data; s_tag = r_tag; s_remain = r_remain;
            s_left = r_left; s_count = r_count; s_hold = r_hold; s_toggle = r_toggle;
        end
    end

    always_comb begin
        n_phase = s_phase; n_fs = s_fs; n_stereo = s_stereo; n_chan_ok = s_chan_ok;
        n_rate = s_rate; n_brate = s_brate; n_wide = s_wide; n_ck_riff = s_ck_riff;
        n_ck_wave = s_ck_wave; n_ck_fmt = s_ck_fmt; n_ck_pcm = s_ck_pcm; n_ck_data = s_ck_data;
        n_remain = s_remain; n_left = s_left; n_count = s_count; n_hold = s_hold;
        n_toggle = s_toggle;
        n_tag = {i_file_byte, s_tag[31:8]};
        n_pos = s_pos + 32'd1;
        half = n_tag[31:16];
        width_ok = (half == 16'd8) || (half == 16'd16);
        frame_end = s_toggle || !s_stereo;
        total = n_tag;
        if (s_wide && s_stereo) begin
            total = {2'b00, n_tag[31:2]};
        end else if (s_wide || s_stereo) begin
            total = {1'b0, n_tag[31:1]};
        end
        o_res_valid = 1'b0;
        o_res = '0;

        case (s_phase)
            PH_HEADER: begin
                if (s_pos == POS_RIFF && n_tag == wpsp_pkg::TAG_RIFF) n_ck_riff = 1'b1;
                if (s_pos == POS_WAVE && n_tag == wpsp_pkg::TAG_WAVE) n_ck_wave = 1'b1;
                if (s_pos == POS_FMT && n_tag == wpsp_pkg::TAG_FMT) n_ck_fmt = 1'b1;
                if (s_pos == POS_PCM && half == wpsp_pkg::PCM_CODE) n_ck_pcm = 1'b1;
                if (s_pos == POS_CHAN) begin
                    n_chan_ok = (half != 16'd0) && (half <= wpsp_pkg::MAX_CHANNELS);
                    n_stereo = (half == wpsp_pkg::MAX_CHANNELS);
                end
                if (s_pos == POS_RATE) n_rate = n_tag;
                if (s_pos == POS_BRATE) n_brate = n_tag;
                if (s_pos == POS_WIDTH) begin
                    n_wide = (half == 16'd16);
                    o_res.kind = wpsp_pkg::KIND_ERROR;
                    o_res_valid = 1'b1;
                    n_phase = PH_IDLE;
                    if (!s_ck_pcm) begin
                        o_res.error_code = wpsp_pkg::ERR_NOT_PCM;
                    end else if (!s_chan_ok) begin
                        o_res.error_code = wpsp_pkg::ERR_CHANNELS;
                    end else if (!s_ck_riff) begin
                        o_res.error_code = wpsp_pkg::ERR_NOT_RIFF;
                    end else if (!s_ck_wave) begin
                        o_res.error_code = wpsp_pkg::ERR_NOT_WAVE;
                    end else if (!s_ck_fmt) begin
                        o_res.error_code = wpsp_pkg::ERR_NO_FMT;
                    end else if (!width_ok) begin
                        o_res.error_code = wpsp_pkg::ERR_BAD_WIDTH;
                    end else begin
                        o_res = '0;
                        o_res_valid = 1'b0;
                        n_phase = PH_CHUNK;
                        n_fs = '0;
                    end
                end
            end
            PH_CHUNK: begin
                if (s_fs == FS_TAG_END) n_ck_data = (n_tag == wpsp_pkg::TAG_DATA);
                if (s_fs != FS_HDR_LAST) begin
                    n_fs = s_fs + 3'd1;
                end else begin
                    n_fs = '0;
                    if (!s_ck_data) begin
                        n_remain = n_tag;
                        n_phase = (n_tag == 32'd0) ? PH_CHUNK : PH_SKIP;
                    end else begin
                        n_left = total;
                        n_count = '0;
                        n_toggle = 1'b0;
                        n_phase = (total == 32'd0) ? PH_IDLE : PH_DATA;
                        o_res_valid = 1'b1;
                        o_res.kind = wpsp_pkg::KIND_FORMAT;
                        o_res.chan_count = s_stereo ? 2'd2 : 2'd1;
                        o_res.sample_bits = s_wide ? 5'd16 : 5'd8;
                        o_res.rate_hz = s_rate;
                        o_res.bytes_per_sec = s_brate;
                        o_res.frame_total = total;
                        o_res.audio_offset = n_pos;
                    end
                end
            end
            PH_SKIP: begin
                n_remain = s_remain - 32'd1;
                if (n_remain == 32'd0) begin
                    n_phase = PH_CHUNK;
                    n_fs = '0;
                end
            end
            PH_DATA: begin
                if (s_wide && s_fs == 3'd0) begin
                    n_hold = i_file_byte;
                    n_fs = 3'd1;
                end else begin
                    n_fs = '0;
                    o_res_valid = 1'b1;
                    o_res.kind = wpsp_pkg::KIND_SAMPLE;
                    o_res.sample_word = s_wide ? {i_file_byte, s_hold} : {8'd0, i_file_byte};
                    o_res.channel = s_toggle;
                    o_res.frame_index = s_count;
                    o_res.last = frame_end && (s_left == 32'd1);
                    if (frame_end) begin
                        n_toggle = 1'b0;
                        n_count = s_count + 32'd1;
                        n_left = s_left - 32'd1;
                        if (s_left == 32'd1) n_phase = PH_IDLE;
                    end else begin
                        n_toggle = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_pos <= '0; r_fs <= '0; r_stereo <= 1'b0;
            r_chan_ok <= 1'b0; r_rate <= '0; r_brate <= '0; r_wide <= 1'b0;
            r_ck_riff <= 1'b0; r_ck_wave <= 1'b0; r_ck_fmt <= 1'b0; r_ck_pcm <= 1'b0;
            r_ck_data <= 1'b0; r_tag <= '0; r_remain <= '0; r_left <= '0; r_count <= '0;
            r_hold <= '0; r_toggle <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_fs <= n_fs; r_stereo <= n_stereo;
            r_chan_ok <= n_chan_ok; r_rate <= n_rate; r_brate <= n_brate; r_wide <= n_wide;
            r_ck_riff <= n_ck_riff; r_ck_wave <= n_ck_wave; r_ck_fmt <= n_ck_fmt;
            r_ck_pcm <= n_ck_pcm; r_ck_data <= n_ck_data; r_tag <= n_tag;
            r_remain <= n_remain; r_left <= n_left; r_count <= n_count; r_hold <= n_hold;
            r_toggle <= n_toggle;
        end
    end

endmodule

`default_nettype wire

/* rtl/wpsp_out_reg.sv */
// Result register between parser logic and the output channel.
// Depends on wpsp_pkg. Refills in the same cycle the held result is taken.
`default_nettype none

module wpsp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic              i_res_valid,
    input  wire wpsp_pkg::t_result i_res,
    input  wire logic              i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output wpsp_pkg::t_result      o_out
);

    logic              r_valid;
    wpsp_pkg::t_result r_res;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_res_valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for wav_pcm_stream_parser_top: WAV byte streams in, results checked.
// Depends on wpsp_pkg, wpsp_stream_if and the parser RTL; an in-bench parser model predicts
// every result.
module tb_top;
    import wpsp_pkg::*;

    typedef enum logic [2:0] {
        ST_HEADER, ST_CHUNK_HDR, ST_SKIP, ST_SAMPLES, ST_IDLE
    } t_parse_state;

    logic clk;
    logic rst_n;

    wpsp_byte_if   in_if();
    wpsp_result_if out_if();

    wav_pcm_stream_parser_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [7:0] pend_byte[$];
    bit         pend_sof[$];
    t_result    expected_results[$];

    int mismatches;
    int bytes_accepted;
    int burst_left;
    int gap_left;
    int rx_cycle;
    int hold_left;
    int next_hold = 150;
    int rx_mode;
    int mode_left;

    // parser model state
    t_parse_state p_state;
    logic [31:0]  p_pos;
    logic [2:0]   p_shift;
    logic [15:0]  p_channels;
    logic [15:0]  p_width;
    logic [31:0]  p_rate;
    logic [31:0]  p_brate;
    logic [31:0]  p_window;
    logic [31:0]  p_skip_left;
    logic [31:0]  p_frames_left;
    logic [31:0]  p_frame_num;
    logic [7:0]   p_low_byte;
    logic         p_right;
    logic         is_riff, is_wave, is_fmt, is_pcm, is_data;

    task automatic parser_restart();
        p_state       = ST_HEADER;
        p_pos         = '0;
        p_shift       = '0;
        p_channels    = '0;
        p_width       = '0;
        p_rate        = '0;
        p_brate       = '0;
        p_window      = '0;
        p_skip_left   = '0;
        p_frames_left = '0;
        p_frame_num   = '0;
        p_low_byte    = '0;
        p_right       = 1'b0;
        is_riff       = 1'b0;
        is_wave       = 1'b0;
        is_fmt        = 1'b0;
        is_pcm        = 1'b0;
        is_data       = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic sof);
        t_result     r;
        bit          emit;
        logic [15:0] half;
        logic [31:0] bpf;
        logic [31:0] total;
        logic        frame_end;
        r    = '0;
        emit = 1'b0;
        if (sof)
            parser_restart();
        p_window = {b, p_window[31:8]};
        half     = p_window[31:16];
        case (p_state)
            ST_HEADER: begin
                case (p_pos)
                    32'd3:  if (p_window == TAG_RIFF) is_riff = 1'b1;
                    32'd11: if (p_window == TAG_WAVE) is_wave = 1'b1;
                    32'd15: if (p_window == TAG_FMT) is_fmt = 1'b1;
                    32'd21: if (half == PCM_CODE) is_pcm = 1'b1;
                    32'd23: p_channels = half;
                    32'd27: p_rate = p_window;
                    32'd31: p_brate = p_window;
                    32'd35: begin
                        p_width = half;
                        emit    = 1'b1;
                        r.kind  = KIND_ERROR;
                        if (!is_pcm)
                            r.error_code = ERR_NOT_PCM;
                        else if (p_channels == 16'd0 || p_channels > MAX_CHANNELS)
                            r.error_code = ERR_CHANNELS;
                        else if (!is_riff)
                            r.error_code = ERR_NOT_RIFF;
                        else if (!is_wave)
                            r.error_code = ERR_NOT_WAVE;
                        else if (!is_fmt)
                            r.error_code = ERR_NO_FMT;
                        else if (p_width != 16'd8 && p_width != 16'd16)
                            r.error_code = ERR_BAD_WIDTH;
                        else begin
                            emit    = 1'b0;
                            r       = '0;
                            p_state = ST_CHUNK_HDR;
                            p_shift = '0;
                        end
                        if (emit)
                            p_state = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            ST_CHUNK_HDR: begin
                if (p_shift == 3'd3)
                    is_data = (p_window == TAG_DATA);
                if (p_shift < 3'd7) begin
                    p_shift = p_shift + 3'd1;
                end else begin
                    p_shift = '0;
                    if (!is_data) begin
                        p_skip_left = p_window;
                        if (p_window == 32'd0)
                            p_state = ST_CHUNK_HDR;
                        else
                            p_state = ST_SKIP;
                    end else begin
                        bpf           = {16'd0, p_width >> 3} * {16'd0, p_channels};
                        total         = p_window / bpf;
                        p_frames_left = total;
                        p_frame_num   = '0;
                        p_right       = 1'b0;
                        if (total == 32'd0)
                            p_state = ST_IDLE;
                        else
                            p_state = ST_SAMPLES;
                        emit            = 1'b1;
                        r.kind          = KIND_FORMAT;
                        r.chan_count    = p_channels[1:0];
                        r.sample_bits   = p_width[4:0];
                        r.rate_hz       = p_rate;
                        r.bytes_per_sec = p_brate;
                        r.frame_total   = total;
                        r.audio_offset  = p_pos + 32'd1;
                    end
                end
            end
            ST_SKIP: begin
                p_skip_left = p_skip_left - 32'd1;
                if (p_skip_left == 32'd0) begin
                    p_state = ST_CHUNK_HDR;
                    p_shift = '0;
                end
            end
            ST_SAMPLES: begin
                if (p_width == 16'd16 && p_shift == 3'd0) begin
                    p_low_byte = b;
                    p_shift    = 3'd1;
                end else begin
                    if (p_width == 16'd16) begin
                        p_shift       = '0;
                        r.sample_word = {b, p_low_byte};
                    end else begin
                        r.sample_word = {8'd0, b};
                    end
                    frame_end     = ({31'd0, p_right} + 32'd1) >= {16'd0, p_channels};
                    emit          = 1'b1;
                    r.kind        = KIND_SAMPLE;
                    r.channel     = p_right;
                    r.frame_index = p_frame_num;
                    r.last        = frame_end && (p_frames_left == 32'd1);
                    if (frame_end) begin
                        p_right       = 1'b0;
                        p_frame_num   = p_frame_num + 32'd1;
                        p_frames_left = p_frames_left - 32'd1;
                        if (p_frames_left == 32'd0)
                            p_state = ST_IDLE;
                    end else begin
                        p_right = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        p_pos = p_pos + 32'd1;
        if (emit)
            expected_results.push_back(r);
    endtask

    function automatic string fmt_result(input t_result r);
        return $sformatf({"kind=%0d word=%h ch=%0d frame=%h last=%0d nch=%0d bits=%0d ",
                          "rate=%h brate=%h total=%h offset=%h err=%0d"},
                         r.kind, r.sample_word, r.channel, r.frame_index, r.last,
                         r.chan_count, r.sample_bits, r.rate_hz, r.bytes_per_sec,
                         r.frame_total, r.audio_offset, r.error_code);
    endfunction

    task automatic put_byte(input logic [7:0] b, input bit sof);
        pend_byte.push_back(b);
        pend_sof.push_back(sof);
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            put_byte(v[8*i +: 8], 1'b0);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            put_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic put_header(input bit sof, input logic [31:0] riff, input logic [31:0] wave,
                              input logic [31:0] fmt_tag, input logic [15:0] fmt,
                              input logic [15:0] ch, input logic [31:0] rate,
                              input logic [31:0] brate, input logic [15:0] bits);
        put_byte(riff[7:0], sof);
        put_le(riff >> 8, 3);
        put_le($urandom, 4);
        put_le(wave, 4);
        put_le(fmt_tag, 4);
        put_le(32'd16, 4);
        put_le({16'd0, fmt}, 2);
        put_le({16'd0, ch}, 2);
        put_le(rate, 4);
        put_le(brate, 4);
        put_le($urandom, 2);
        put_le({16'd0, bits}, 2);
    endtask

    task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size);
        put_le(tag, 4);
        put_le(size, 4);
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

    // byte driver
    always @(posedge clk) begin : drv
        logic       nv;
        logic [7:0] nb;
        logic       ns;
        if (!rst_n) begin
            in_if.valid         <= 1'b0;
            in_if.file_byte     <= 8'd0;
            in_if.start_of_file <= 1'b0;
        end else begin
            nv = in_if.valid;
            nb = in_if.file_byte;
            ns = in_if.start_of_file;
            if (in_if.valid && in_if.ready) begin
                predict_byte(in_if.file_byte, in_if.start_of_file);
                bytes_accepted++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_byte.size() > 0) begin
                    nv = 1'b1;
                    nb = pend_byte.pop_front();
                    ns = pend_sof.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                                 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_if.valid         <= nv;
            in_if.file_byte     <= nb;
            in_if.start_of_file <= ns;
        end
    end

    // result receiver: stall pattern plus occasional long hold-off
    always @(posedge clk) begin : rx
        rx_cycle++;
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (out_if.valid && rx_cycle >= next_hold) begin
            hold_left    = 80;
            next_hold    = rx_cycle + 1000;
            out_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= 1'($urandom_range(0, 1));
                2:       out_if.ready <= (rx_cycle % 4 == 0);
                default: out_if.ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk) begin : mon
        t_result act;
        t_result exp_r;
        if (rst_n && out_if.valid && out_if.ready) begin
            act.kind          = out_if.kind;
            act.sample_word   = out_if.sample_word;
            act.channel       = out_if.channel;
            act.frame_index   = out_if.frame_index;
            act.last          = out_if.last;
            act.chan_count    = out_if.chan_count;
            act.sample_bits   = out_if.sample_bits;
            act.rate_hz       = out_if.rate_hz;
            act.bytes_per_sec = out_if.bytes_per_sec;
            act.frame_total   = out_if.frame_total;
            act.audio_offset  = out_if.audio_offset;
            act.error_code    = out_if.error_code;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %s", fmt_result(act));
            end else begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch expected: %s", fmt_result(exp_r));
                        $display("         actual:   %s", fmt_result(act));
                    end
                end
            end
        end
    end

    initial begin : stim
        int          random_bytes;
        int          total_bytes;
        int          n0;
        int          sel;
        int          k;
        logic [15:0] ch;
        logic [15:0] bits;
        logic [31:0] sz;
        in_if.valid         = 1'b0;
        in_if.file_byte     = 8'd0;
        in_if.start_of_file = 1'b0;
        out_if.ready        = 1'b0;
        rst_n               = 1'b0;
        parser_restart();

        // mono 8-bit, first file with no start marker, trailing bytes after data
        put_header(0, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'd1, 32'hFFFF_FFFF, 32'd0, 16'd8);
        put_chunk(TAG_DATA, 32'd3);
        put_byte(8'h00, 0);
        put_byte(8'hFF, 0);
        put_byte(8'h80, 0);
        put_noise(2);
        // stereo 16-bit, empty chunk, skipped chunk, partial frame at the end
        put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'd2, 32'd44100, 32'd176400,
                   16'd16);
        put_chunk(32'h5453_494C, 32'd0);
        put_chunk(32'h7473_6166, 32'd3);
        put_noise(3);
        put_chunk(TAG_DATA, 32'd9);
        put_le(32'hFFFF_0000, 4);
        put_le(32'h7FFF_8000, 4);
        put_noise(3);
        // data chunk with no whole frame
        put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'd2, 32'd8000, 32'd16000, 16'd8);
        put_chunk(TAG_DATA, 32'd1);
        put_noise(3);
        // huge data chunk cut short by a restart
        put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'd1, 32'd0, 32'hFFFF_FFFF,
                   16'd16);
        put_chunk(TAG_DATA, 32'hFFFF_FFFF);
        put_noise(7);
        // header errors, in check order
        put_header(1, 32'd0, TAG_WAVE, TAG_FMT, 16'd3, 16'd0, $urandom, $urandom, 16'd24);
        put_noise(2);
        put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'd0, $urandom, $urandom, 16'd8);
        put_noise(2);
        put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'h0103, $urandom, $urandom,
                   16'd8);
        put_noise(2);
        put_header(1, TAG_RIFF ^ 32'd1, 32'd0, TAG_FMT, PCM_CODE, 16'd1, $urandom, $urandom,
                   16'd8);
        put_noise(2);
        put_header(1, TAG_RIFF, TAG_WAVE ^ 32'h8000_0000, 32'd0, PCM_CODE, 16'd2, $urandom,
                   $urandom, 16'd16);
        put_noise(2);
        put_header(1, TAG_RIFF, TAG_WAVE, 32'hFFFF_FFFF, PCM_CODE, 16'd2, $urandom, $urandom,
                   16'd0);
        put_noise(2);
        put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'd1, $urandom, $urandom, 16'd24);
        put_noise(2);
        put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, 16'd2, $urandom, $urandom,
                   16'hFFFF);
        put_noise(2);

        random_bytes = 0;
        while (random_bytes < 60) begin
            n0   = pend_byte.size();
            sel  = $urandom_range(0, 19);
            ch   = 16'($urandom_range(1, 2));
            bits = ($urandom_range(0, 1) == 1) ? 16'd16 : 16'd8;
            if (sel < 14) begin
                put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, ch, $urandom, $urandom,
                           bits);
                repeat ($urandom_range(0, 2)) begin
                    sz = $urandom_range(0, 10);
                    put_chunk($urandom, sz);
                    put_noise(sz);
                end
                if ($urandom_range(0, 9) == 0) begin
                    put_chunk(TAG_DATA, $urandom | 32'h8000_0000);
                    put_noise($urandom_range(4, 30));
                end else begin
                    sz = $urandom_range(0, 24);
                    put_chunk(TAG_DATA, sz);
                    put_noise(sz + $urandom_range(0, 3));
                end
            end else if (sel < 17) begin
                // one corrupted byte in the header or the data chunk header
                put_header(1, TAG_RIFF, TAG_WAVE, TAG_FMT, PCM_CODE, ch, $urandom, $urandom,
                           bits);
                sz = $urandom_range(0, 12);
                put_chunk(TAG_DATA, sz);
                pend_byte[n0 + $urandom_range(0, 43)] = 8'($urandom_range(0, 255));
                put_noise(sz);
            end else begin
                repeat ($urandom_range(1, 40))
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            random_bytes += pend_byte.size() - n0;
        end
        total_bytes = pend_byte.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted < total_bytes)
            @(posedge clk);
        k = 0;
        while (expected_results.size() > 0 && k < 5000) begin
            @(posedge clk);
            k++;
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/wpsp_pkg.sv
rtl/wpsp_stream_if.sv
rtl/wpsp_core.sv
rtl/wpsp_out_reg.sv
rtl/wav_pcm_stream_parser_top.sv
tb/tb_top.sv
